// ----- hw/rtl/tlps_pkg.sv -----
// Package for the text range line parser: command and result types,
// character codes and field widths. No dependencies.
package tlps_pkg;

  localparam int NUM_W  = 17;
  localparam int SM_W   = 24;
  localparam int DIST_W = 16;
  localparam int OFF_W  = 11;
  localparam int WGT_W  = 9;

  localparam logic [NUM_W-1:0] NUM_SAT    = 17'd131071;
  localparam logic [WGT_W-1:0] WGT_FULL   = 9'd256;
  localparam logic [WGT_W-1:0] WGT_RESET  = 9'd77;
  localparam logic [DIST_W-1:0] DIST_MAX  = 16'hFFFF;

  // Configuration register indexes
  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_WEIGHT = 1'b1;

  // Characters
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UO    = 8'h4F;  // 'O'
  localparam logic [7:0] CH_UN    = 8'h4E;  // 'N'
  localparam logic [7:0] CH_UF    = 8'h46;  // 'F'
  localparam logic [7:0] CH_UR    = 8'h52;  // 'R'
  localparam logic [7:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [7:0] CH_LN    = 8'h6E;  // 'n'
  localparam logic [7:0] CH_LG    = 8'h67;  // 'g'
  localparam logic [7:0] CH_LE    = 8'h65;  // 'e'

  typedef enum logic [1:0] {
    KIND_ON    = 2'd0,
    KIND_OFF   = 2'd1,
    KIND_RANGE = 2'd2
  } line_kind_t;

  // Recognized line handed from the parser to the update stage
  typedef struct packed {
    line_kind_t       kind;
    logic [NUM_W-1:0] num;
    logic             neg;
  } cmd_t;

  // Finished result; distance is carried as the Q16.8 average
  typedef struct packed {
    line_kind_t      kind;
    logic            present;
    logic            zero;
    logic [SM_W-1:0] sm;
  } res_t;

endpackage

// ----- hw/rtl/tlps_fifo.sv -----
// Small register queue used between the parser, the update stage and the
// result port. No dependencies.
module tlps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tlps_front.sv -----
// Line parser: matches ON, OFF and "Range <number>" one byte at a time and
// issues one command per recognized line. Depends on tlps_pkg.
module tlps_front #(
  parameter int LINE_MAX = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           byte_valid,
  input  logic [7:0]     rx_byte,
  output logic           cmd_valid,
  output tlps_pkg::cmd_t cmd
);
  import tlps_pkg::*;

  localparam int LEN_W = $clog2(LINE_MAX + 1);

  typedef enum logic [3:0] {
    PH_START, PH_O, PH_ON, PH_OF, PH_OFF, PH_R, PH_RA, PH_RAN, PH_RANG,
    PH_RANGE, PH_SPACE, PH_SIGN, PH_DIGITS, PH_DONE, PH_REJECT
  } phase_t;

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] line_len;
  logic [NUM_W-1:0] num, num_next;
  logic             neg, neg_next;
  logic             is_cr, is_lf, is_blank, is_digit;
  logic [20:0]      num_x10;
  logic [NUM_W-1:0] num_dig;
  logic             overlong;
  logic             known;
  line_kind_t       kind;

  assign is_cr    = (rx_byte == CH_CR);
  assign is_lf    = (rx_byte == CH_LF);
  assign is_blank = (rx_byte == CH_SPACE) || (rx_byte == CH_TAB) ||
                    (rx_byte == CH_VT) || (rx_byte == CH_FF);
  assign is_digit = (rx_byte >= CH_0) && (rx_byte <= CH_9);

  // num*10 + digit, saturated
  assign num_x10 = {num, 3'b000} + {2'b00, num, 1'b0} + {17'd0, rx_byte[3:0]};
  assign num_dig = (num_x10 > {4'd0, NUM_SAT}) ? NUM_SAT : num_x10[NUM_W-1:0];

  always_comb begin
    phase_next = PH_REJECT;
    num_next   = num;
    neg_next   = neg;
    case (phase)
      PH_START: phase_next = (rx_byte == CH_UO) ? PH_O :
                             (rx_byte == CH_UR) ? PH_R : PH_REJECT;
      PH_O:     phase_next = (rx_byte == CH_UN) ? PH_ON :
                             (rx_byte == CH_UF) ? PH_OF : PH_REJECT;
      PH_OF:    phase_next = (rx_byte == CH_UF) ? PH_OFF : PH_REJECT;
      PH_R:     phase_next = (rx_byte == CH_LA) ? PH_RA : PH_REJECT;
      PH_RA:    phase_next = (rx_byte == CH_LN) ? PH_RAN : PH_REJECT;
      PH_RAN:   phase_next = (rx_byte == CH_LG) ? PH_RANG : PH_REJECT;
      PH_RANG:  phase_next = (rx_byte == CH_LE) ? PH_RANGE : PH_REJECT;
      PH_RANGE: phase_next = (rx_byte == CH_SPACE) ? PH_SPACE : PH_REJECT;
      PH_SPACE: begin
        if (is_blank) begin
          phase_next = PH_SPACE;
        end else if (rx_byte == CH_MINUS) begin
          neg_next   = 1'b1;
          phase_next = PH_SIGN;
        end else if (rx_byte == CH_PLUS) begin
          phase_next = PH_SIGN;
        end else if (is_digit) begin
          num_next   = num_dig;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_SIGN, PH_DIGITS: begin
        if (is_digit) begin
          num_next   = num_dig;
          phase_next = PH_DIGITS;
        end else begin
          phase_next = PH_DONE;
        end
      end
      PH_DONE:  phase_next = PH_DONE;
      default:  phase_next = PH_REJECT;
    endcase
  end

  always_comb begin
    known = 1'b1;
    kind  = KIND_RANGE;
    case (phase)
      PH_ON:  kind = KIND_ON;
      PH_OFF: kind = KIND_OFF;
      PH_SPACE, PH_SIGN, PH_DIGITS, PH_DONE: kind = KIND_RANGE;
      default: known = 1'b0;
    endcase
  end

  assign overlong  = (line_len >= LEN_W'(LINE_MAX));
  assign cmd_valid = byte_valid && is_lf && !overlong && known;
  assign cmd.kind  = kind;
  assign cmd.num   = num;
  assign cmd.neg   = neg;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      line_len <= '0;
      num      <= '0;
      neg      <= 1'b0;
    end else if (byte_valid && !is_cr) begin
      if (is_lf) begin
        phase    <= PH_START;
        line_len <= '0;
        num      <= '0;
        neg      <= 1'b0;
      end else begin
        if (!overlong) begin
          line_len <= line_len + 1'b1;
        end
        phase <= phase_next;
        num   <= num_next;
        neg   <= neg_next;
      end
    end
  end

endmodule

// ----- hw/rtl/tlps_back.sv -----
// Update stage: applies offset and clamp, then updates the Q16.8 average
// and presence, producing one result per command. Depends on tlps_pkg.
module tlps_back (
  input  logic                       clk,
  input  logic                       rst,
  input  logic signed [10:0]         offset,
  input  logic [8:0]                 weight,
  input  logic                       cmd_empty,
  input  tlps_pkg::cmd_t             cmd,
  output logic                       cmd_pop,
  input  logic                       res_full,
  output logic                       res_push,
  output tlps_pkg::res_t             res
);
  import tlps_pkg::*;

  // Stage A: clamped sample
  logic              a_valid;
  line_kind_t        a_kind;
  logic [DIST_W-1:0] a_val;
  logic              a_load;
  logic              fire;

  logic signed [18:0] raw;
  logic signed [18:0] adj;
  logic [DIST_W-1:0]  clamped;

  // Stage B: state
  logic [SM_W-1:0]   sm, sm_next;
  logic              started;
  logic              present, present_next;
  logic [SM_W-1:0]   shown_sm, shown_sm_next;
  logic              shown_zero, shown_zero_next;

  logic [WGT_W-1:0]   w_eff;
  logic signed [25:0] diff;
  logic signed [35:0] prod;
  logic signed [27:0] step;
  logic [SM_W-1:0]    seed;

  assign fire    = a_valid && !res_full;
  assign a_load  = !cmd_empty && (!a_valid || fire);
  assign cmd_pop = a_load;

  assign raw = cmd.neg ? -$signed({2'b00, cmd.num}) : $signed({2'b00, cmd.num});
  assign adj = raw + 19'(offset);
  always_comb begin
    if (adj < 0) begin
      clamped = '0;
    end else if (adj > 19'sd65535) begin
      clamped = DIST_MAX;
    end else begin
      clamped = adj[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_kind <= cmd.kind;
      a_val  <= clamped;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (a_load) begin
      a_valid <= 1'b1;
    end else if (fire) begin
      a_valid <= 1'b0;
    end
  end

  // avg + ((w*(a*256 - avg) + 128) >>> 8), same as the weighted sum form
  assign w_eff = (weight > WGT_FULL) ? WGT_FULL : weight;
  assign seed  = {a_val, 8'h00};
  assign diff  = $signed({2'b00, seed}) - $signed({2'b00, sm});
  assign prod  = $signed({1'b0, w_eff}) * diff;
  assign step  = 28'((prod + 36'sd128) >>> 8);

  always_comb begin
    sm_next         = sm;
    present_next    = present;
    shown_sm_next   = shown_sm;
    shown_zero_next = shown_zero;
    case (a_kind)
      KIND_ON: begin
        present_next = 1'b1;
      end
      KIND_OFF: begin
        present_next    = 1'b0;
        shown_zero_next = 1'b1;
      end
      KIND_RANGE: begin
        sm_next         = started ? SM_W'($signed({4'b0000, sm}) + step) : seed;
        shown_sm_next   = sm_next;
        shown_zero_next = 1'b0;
      end
      default: begin
        present_next = present;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sm         <= '0;
      started    <= 1'b0;
      present    <= 1'b0;
      shown_sm   <= '0;
      shown_zero <= 1'b1;
    end else if (fire) begin
      sm         <= sm_next;
      present    <= present_next;
      shown_sm   <= shown_sm_next;
      shown_zero <= shown_zero_next;
      if (a_kind == KIND_RANGE) begin
        started <= 1'b1;
      end
    end
  end

  assign res_push    = fire;
  assign res.kind    = a_kind;
  assign res.present = present_next;
  assign res.zero    = shown_zero_next;
  assign res.sm      = shown_sm_next;

endmodule

// ----- hw/rtl/text_range_line_parser_with_smoothing_core.sv -----
// Top level of the text range line parser with smoothing.
// Depends on tlps_pkg, tlps_fifo, tlps_front and tlps_back.
//
//   Channel   Handshake            Payload
//   --------  -------------------  --------------------------------------
//   bytes in  push / full          rx_byte[7:0]
//   results   pop / empty          line_kind[1:0], person_present,
//                                  distance_cm[15:0]
//   config    cfg_we (no wait)     cfg_index, cfg_data[10:0]
//
// One byte is taken every cycle while full is low. A line recognized at its
// LF passes through the command queue, the clamp stage and the result queue
// before reaching the result ports; the averaging step and its multiplier
// run as the result is written into the result queue.
// rst is synchronous and clears parser, average, presence and queues; the
// offset returns to 0 and the weight to 77. full rises only when the
// command queue backs up behind a stalled result port; the parser never
// stalls on its own.
module text_range_line_parser_with_smoothing_core #(
  parameter int LINE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  // results
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  line_kind,
  output logic        person_present,
  output logic [15:0] distance_cm,
  // configuration
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [10:0] cfg_data
);
  import tlps_pkg::*;

  localparam int CMD_DEPTH = 2;
  localparam int RES_DEPTH = 2;

  // Configuration registers
  logic signed [OFF_W-1:0] distance_offset_cm;
  logic [WGT_W-1:0]        smoothing_weight;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_offset_cm <= '0;
      smoothing_weight   <= WGT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OFFSET: distance_offset_cm <= cfg_data;
        REG_WEIGHT: smoothing_weight   <= cfg_data[WGT_W-1:0];
        default:    smoothing_weight   <= smoothing_weight;
      endcase
    end
  end

  // Front: parse the byte stream; take a byte whenever the command queue
  // has room
  logic  byte_take;
  logic  cmd_valid;
  cmd_t  cmd_in;
  cmd_t  cmd_head;
  logic  cmd_full;
  logic  cmd_empty;
  logic  cmd_pop;

  assign full      = cmd_full;
  assign byte_take = push && !cmd_full;

  tlps_front #(
    .LINE_MAX(LINE_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .byte_valid(byte_take),
    .rx_byte   (rx_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_in)
  );

  // Hold recognized lines until the update stage takes them
  tlps_fifo #(
    .WIDTH($bits(cmd_t)),
    .DEPTH(CMD_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst  (rst),
    .push (cmd_valid),
    .wdata(cmd_in),
    .full (cmd_full),
    .pop  (cmd_pop),
    .rdata(cmd_head),
    .empty(cmd_empty)
  );

  // Back: clamp, average, presence
  logic res_push;
  logic res_full;
  res_t res_in;
  res_t res_head;

  tlps_back u_back (
    .clk      (clk),
    .rst      (rst),
    .offset   (distance_offset_cm),
    .weight   (smoothing_weight),
    .cmd_empty(cmd_empty),
    .cmd      (cmd_head),
    .cmd_pop  (cmd_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  // Result queue parts the update stage from the consumer
  tlps_fifo #(
    .WIDTH($bits(res_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res_in),
    .full (res_full),
    .pop  (pop),
    .rdata(res_head),
    .empty(empty)
  );

  // Round the Q16.8 average to centimetres; saturate at the top
  logic [SM_W:0] rounded;

  assign rounded        = {1'b0, res_head.sm} + (SM_W + 1)'(128);
  assign line_kind      = res_head.kind;
  assign person_present = res_head.present;
  assign distance_cm    = res_head.zero     ? '0 :
                          rounded[SM_W]     ? DIST_MAX :
                          rounded[SM_W-1:8];

endmodule
